// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the fan PID regulator.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define FPID_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("%m: assertion failed");
// Condition that must never be true outside reset.
`define FPID_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("%m: forbidden condition seen");
`else
`define FPID_ASSERT(lbl, clk, rst_n, prop)
`define FPID_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/fpid_pkg.sv
// Package of the fan PID regulator: widths, codes, sequencer states and duty table.
// Used by fan_pid_temperature_control_core; depends on nothing else.
package fpid_pkg;

	// Field widths
	localparam int TEMP_W  = 17;
	localparam int GAIN_W  = 16;
	localparam int LEVEL_W = 8;
	localparam int INTEG_W = 32;
	localparam int DELTA_W = 18;
	localparam int DUTY_W  = 16;
	localparam int STAT_W  = 2;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	// Datapath widths: product of the shared multiplier, accumulator, scaled sum
	localparam int PROD_W = INTEG_W + GAIN_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int CAND_W = ACC_W - 16;

	// Fan constants
	localparam int PWM_MAX   = 255;
	localparam int PERIOD_NS = 40000;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_TARGET_TEMP    = 3'd0;
	localparam logic [2:0] REG_OVERHEAT_TEMP  = 3'd1;
	localparam logic [2:0] REG_GAIN_P         = 3'd2;
	localparam logic [2:0] REG_GAIN_I         = 3'd3;
	localparam logic [2:0] REG_GAIN_D         = 3'd4;
	localparam logic [2:0] REG_PWM_FLOOR      = 3'd5;
	localparam logic [2:0] REG_START_PWM      = 3'd6;
	localparam logic [2:0] REG_START_INTEGRAL = 3'd7;

	// Request kinds
	localparam logic REQ_SAMPLE  = 1'b0;
	localparam logic REQ_RESTART = 1'b1;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_REGULATED = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OVERHEAT  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NO_BOARDS = 2'd2;
	localparam logic [STAT_W-1:0] STAT_RESTART   = 2'd3;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_ACC,
		ST_SCALE,
		ST_APPLY,
		ST_FINISH
	} fpid_state_t;

	// Duty in nanoseconds for every PWM level, built at elaboration.
	typedef logic [DUTY_W-1:0] duty_lut_t [2**LEVEL_W];

	function automatic duty_lut_t build_duty_lut();
		duty_lut_t lut;
		for (int i = 0; i < 2**LEVEL_W; i++) begin
			lut[i] = DUTY_W'((PERIOD_NS * i) / PWM_MAX);
		end
		return lut;
	endfunction

	localparam duty_lut_t DUTY_LUT = build_duty_lut();

endpackage

// File: rtl/fan_pid_temperature_control_core.sv
// Fan PID regulator: request sequencer, shared multiplier datapath and config registers.
// Depends on fpid_pkg and assert_macros.svh.
//
// A regulated sample goes through update, the P, I and D passes of the one 32x16 multiplier,
// accumulate, scale, apply (clamp) and finish; restart and overheat go from update to apply
// and finish; a sample with no boards goes from update to finish. One request is in work at
// a time: no new request is taken until the result of the last one is loaded.
// Reset (arst_n low) loads the register defaults and clears the loop state to warm-up mode.
`include "assert_macros.svh"

module fan_pid_temperature_control_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Request channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 req_type,
	input  logic signed [fpid_pkg::TEMP_W-1:0]   temperature,
	input  logic                                 boards_active,
	// Result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [fpid_pkg::LEVEL_W-1:0]         pwm_level,
	output logic [fpid_pkg::DUTY_W-1:0]          duty_ns,
	output logic                                 written,
	output logic [fpid_pkg::STAT_W-1:0]          status,
	// Configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [fpid_pkg::ADDR_W-1:0]          paddr,
	input  logic [fpid_pkg::DATA_W-1:0]          pwdata,
	output logic [fpid_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready
);
	import fpid_pkg::*;

	// Sequencer
	fpid_state_t state_q, state_d;

	// Configuration registers
	logic signed [TEMP_W-1:0]  target_temp_q, overheat_temp_q;
	logic signed [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic [LEVEL_W-1:0]        pwm_floor_q, start_pwm_q;
	logic signed [INTEG_W-1:0] start_integral_q;

	// Loop state
	logic signed [TEMP_W-1:0]  last_error_q;
	logic signed [INTEG_W-1:0] integral_q;
	logic signed [DELTA_W-1:0] error_delta_q;
	logic                      pid_mode_q;
	logic [LEVEL_W-1:0]        applied_level_q;

	// Captured request
	logic                      req_type_q;
	logic signed [TEMP_W-1:0]  temp_q;
	logic                      boards_q;

	// Datapath registers
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [CAND_W-1:0]  cand_q;
	logic                      written_q;
	logic [STAT_W-1:0]         status_q;

	// Result register
	logic                      out_valid_q;
	logic [LEVEL_W-1:0]        pwm_level_q;
	logic [DUTY_W-1:0]         duty_ns_q;
	logic                      written_out_q;
	logic [STAT_W-1:0]         status_out_q;

	// Control decoded from the state
	logic in_fire, cfg_we, out_load;
	logic is_restart, no_boards, is_overheat;

	// Update arithmetic
	logic signed [DELTA_W-1:0] err_wide, delta_new;
	logic signed [TEMP_W-1:0]  err_sat;
	logic signed [TEMP_W-8:0]  temp_deg, target_deg;
	logic signed [INTEG_W:0]   int_step, int_sum;
	logic signed [INTEG_W-1:0] int_sat;
	logic                      warm_equal;

	// Shared multiplier and level logic
	logic signed [INTEG_W-1:0] mul_a;
	logic signed [GAIN_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]  mul_prod;
	logic signed [ACC_W-1:0]   prod_ext, acc_adj;
	logic [LEVEL_W-1:0]        level_clamped;

	// Configuration write and read
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_comb begin
		case (paddr[4:2])
			REG_TARGET_TEMP:    prdata = DATA_W'(target_temp_q);
			REG_OVERHEAT_TEMP:  prdata = DATA_W'(overheat_temp_q);
			REG_GAIN_P:         prdata = DATA_W'(gain_p_q);
			REG_GAIN_I:         prdata = DATA_W'(gain_i_q);
			REG_GAIN_D:         prdata = DATA_W'(gain_d_q);
			REG_PWM_FLOOR:      prdata = {{(DATA_W-LEVEL_W){1'b0}}, pwm_floor_q};
			REG_START_PWM:      prdata = {{(DATA_W-LEVEL_W){1'b0}}, start_pwm_q};
			REG_START_INTEGRAL: prdata = start_integral_q;
			default:            prdata = '0;
		endcase
	end

	// Request kind decode from the captured request
	assign is_restart  = (req_type_q == REQ_RESTART);
	assign no_boards   = !boards_q;
	assign is_overheat = (temp_q > overheat_temp_q);

	// Next-state logic
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (is_restart) state_d = ST_APPLY;
				else if (no_boards) state_d = ST_FINISH;
				else if (is_overheat) state_d = ST_APPLY;
				else state_d = ST_MUL_P;
			end
			ST_MUL_P: state_d = ST_MUL_I;
			ST_MUL_I: state_d = ST_MUL_D;
			ST_MUL_D: state_d = ST_ACC;
			ST_ACC:   state_d = ST_SCALE;
			ST_SCALE: state_d = ST_APPLY;
			ST_APPLY: state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output decode of the sequencer
	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_FINISH: out_load = !out_valid_q || out_ready;
			default: begin
				in_ready = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	assign in_fire = in_valid & in_ready;

	// Error, its saturation to the stored width and the new derivative term
	assign err_wide = {temp_q[TEMP_W-1], temp_q} - {target_temp_q[TEMP_W-1], target_temp_q};

	always_comb begin
		if (err_wide[DELTA_W-1] != err_wide[DELTA_W-2]) begin
			err_sat = err_wide[DELTA_W-1] ? {1'b1, {(TEMP_W-1){1'b0}}}
			                              : {1'b0, {(TEMP_W-1){1'b1}}};
		end else begin
			err_sat = err_wide[TEMP_W-1:0];
		end
	end

	assign delta_new = {err_sat[TEMP_W-1], err_sat} - {last_error_q[TEMP_W-1], last_error_q};

	// Whole degrees, truncated toward zero
	assign temp_deg = (TEMP_W-7)'(temp_q >>> 8)
		+ $signed({{(TEMP_W-8){1'b0}}, temp_q[TEMP_W-1] && (temp_q[7:0] != 8'd0)});
	assign target_deg = (TEMP_W-7)'(target_temp_q >>> 8)
		+ $signed({{(TEMP_W-8){1'b0}},
			target_temp_q[TEMP_W-1] && (target_temp_q[7:0] != 8'd0)});
	assign warm_equal = (temp_deg == target_deg);

	// Integral step and saturating add
	always_comb begin
		if (pid_mode_q) begin
			int_step = (INTEG_W+1)'(err_sat);
		end else if (temp_deg < target_deg) begin
			int_step = -(INTEG_W+1)'(128);
		end else begin
			int_step = (INTEG_W+1)'(256);
		end
	end

	assign int_sum = {integral_q[INTEG_W-1], integral_q} + int_step;

	always_comb begin
		if (int_sum[INTEG_W] != int_sum[INTEG_W-1]) begin
			int_sat = int_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
			                           : {1'b0, {(INTEG_W-1){1'b1}}};
		end else begin
			int_sat = int_sum[INTEG_W-1:0];
		end
	end

	// Operand selection for the shared multiplier
	always_comb begin
		case (state_q)
			ST_MUL_P: begin
				mul_a = INTEG_W'(last_error_q);
				mul_b = gain_p_q;
			end
			ST_MUL_I: begin
				mul_a = integral_q;
				mul_b = gain_i_q;
			end
			ST_MUL_D: begin
				mul_a = INTEG_W'(error_delta_q);
				mul_b = gain_d_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_prod = mul_a * mul_b;
	assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

	// Division by 65536 rounding toward zero
	assign acc_adj = acc_q + (acc_q[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0));

	// Clamp: the floor wins over the ceiling
	always_comb begin
		if (cand_q < $signed({{(CAND_W-LEVEL_W){1'b0}}, pwm_floor_q})) begin
			level_clamped = pwm_floor_q;
		end else if (cand_q > CAND_W'(PWM_MAX)) begin
			level_clamped = LEVEL_W'(PWM_MAX);
		end else begin
			level_clamped = cand_q[LEVEL_W-1:0];
		end
	end

	// Control state, configuration and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			target_temp_q    <= TEMP_W'(17920);
			overheat_temp_q  <= TEMP_W'(23040);
			gain_p_q         <= '0;
			gain_i_q         <= GAIN_W'(256);
			gain_d_q         <= '0;
			pwm_floor_q      <= '0;
			start_pwm_q      <= LEVEL_W'(255);
			start_integral_q <= '0;
			last_error_q     <= '0;
			integral_q       <= '0;
			error_delta_q    <= '0;
			pid_mode_q       <= 1'b0;
			applied_level_q  <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (paddr[4:2])
					REG_TARGET_TEMP:    target_temp_q    <= pwdata[TEMP_W-1:0];
					REG_OVERHEAT_TEMP:  overheat_temp_q  <= pwdata[TEMP_W-1:0];
					REG_GAIN_P:         gain_p_q         <= pwdata[GAIN_W-1:0];
					REG_GAIN_I:         gain_i_q         <= pwdata[GAIN_W-1:0];
					REG_GAIN_D:         gain_d_q         <= pwdata[GAIN_W-1:0];
					REG_PWM_FLOOR:      pwm_floor_q      <= pwdata[LEVEL_W-1:0];
					REG_START_PWM:      start_pwm_q      <= pwdata[LEVEL_W-1:0];
					REG_START_INTEGRAL: start_integral_q <= pwdata;
					default:            start_integral_q <= start_integral_q;
				endcase
			end

			// Loop state update for the captured request
			if (state_q == ST_UPDATE) begin
				if (is_restart) begin
					integral_q <= start_integral_q;
				end else if (!no_boards && !is_overheat) begin
					if (pid_mode_q) begin
						last_error_q  <= err_sat;
						error_delta_q <= delta_new;
						integral_q    <= int_sat;
					end else if (warm_equal) begin
						pid_mode_q <= 1'b1;
					end else begin
						integral_q <= int_sat;
					end
				end
			end

			if (state_q == ST_APPLY) begin
				applied_level_q <= level_clamped;
			end

			// Result valid flag
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_type_q <= req_type;
			temp_q     <= temperature;
			boards_q   <= boards_active;
		end

		// Choose the starting point of the result for each request kind
		if (state_q == ST_UPDATE) begin
			written_q <= 1'b0;
			if (is_restart) begin
				cand_q   <= $signed({{(CAND_W-LEVEL_W){1'b0}}, start_pwm_q});
				status_q <= STAT_RESTART;
			end else if (no_boards) begin
				status_q <= STAT_NO_BOARDS;
			end else if (is_overheat) begin
				cand_q   <= CAND_W'(PWM_MAX);
				status_q <= STAT_OVERHEAT;
			end else begin
				status_q <= STAT_REGULATED;
			end
		end

		// Multiply and accumulate the three terms
		case (state_q)
			ST_MUL_P: prod_q <= mul_prod;
			ST_MUL_I: begin
				prod_q <= mul_prod;
				acc_q  <= prod_ext;
			end
			ST_MUL_D: begin
				prod_q <= mul_prod;
				acc_q  <= acc_q + prod_ext;
			end
			ST_ACC:   acc_q  <= acc_q + prod_ext;
			ST_SCALE: cand_q <= acc_adj[ACC_W-1:16];
			default:  prod_q <= prod_q;
		endcase

		if (state_q == ST_APPLY) begin
			written_q <= (level_clamped != applied_level_q);
		end

		if (out_load) begin
			pwm_level_q   <= applied_level_q;
			duty_ns_q     <= DUTY_LUT[applied_level_q];
			written_out_q <= written_q;
			status_out_q  <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pwm_level = pwm_level_q;
	assign duty_ns   = duty_ns_q;
	assign written   = written_out_q;
	assign status    = status_out_q;

	// Checks on the sequencer and the result
	`FPID_ASSERT(a_busy_after_request, clk, arst_n, in_fire |=> !in_ready)
	`FPID_ASSERT(a_result_loaded, clk, arst_n, out_load |=> out_valid_q)
	`FPID_ASSERT(a_duty_in_range, clk, arst_n, out_valid_q |-> duty_ns_q <= DUTY_W'(PERIOD_NS))
	`FPID_NEVER(a_pid_mode_sticky, clk, arst_n, $fell(pid_mode_q))
	`FPID_ASSERT(a_overheat_full, clk, arst_n, out_valid_q && status_out_q == STAT_OVERHEAT |-> pwm_level_q == LEVEL_W'(PWM_MAX))

endmodule
